@@ sv/wtag_pkg.sv @@
// ----------------------------------------------------------------------------
// wtag_pkg: shared types and constants of the wheel tachometer
// Field widths, register codes, arithmetic constants and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package wtag_pkg;

  // Configuration register codes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_TEETH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAMETER = 1'd1;

  localparam int COG_W   = 16;
  localparam int DIAM_W  = 20;
  localparam int CAP_W   = 32;
  localparam int FREQ_W  = 27;
  localparam int LEN_W   = 9;
  localparam int WIN_W   = 8;
  localparam int OUT_W   = 49;
  localparam int Q_FRAC  = 16;

  localparam logic [COG_W-1:0]  TEETH_RESET    = 16'd45;
  localparam logic [DIAM_W-1:0] DIAMETER_RESET = 20'd10486;
  localparam logic [LEN_W-1:0]  INITIAL_WINDOW = 9'd500;

  localparam logic [FREQ_W-1:0] TIMER_CLOCK_HZ = 27'd72000000;
  // pi * 3.6 in Q4.16
  localparam logic [19:0]       SPEED_K_Q16    = 20'd741197;
  localparam int                SPEED_SHIFT    = 32;

  localparam int WINDOW_SCALE = 1000;
  localparam int MIN_WINDOW   = 10;
  localparam int MAX_WINDOW   = 200;
  localparam logic [WIN_W-1:0]  MIN_WINDOW_MS = WIN_W'(MIN_WINDOW);
  localparam logic [WIN_W-1:0]  MAX_WINDOW_MS = WIN_W'(MAX_WINDOW);
  // integer rps at or below this gives the longest window, above the fast
  // limit the shortest one
  localparam logic [FREQ_W-1:0] IRPS_SLOW_MAX = FREQ_W'(WINDOW_SCALE / MAX_WINDOW);
  localparam logic [FREQ_W-1:0] IRPS_FAST_MAX = FREQ_W'(WINDOW_SCALE / MIN_WINDOW);

  // Serial divider: dividend is wide enough for the frequency with 16 fraction bits
  localparam int DIV_N_W   = FREQ_W + Q_FRAC;
  localparam int DIV_D_W   = CAP_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Serial multiplier: rps (43 bits) times diameter * K (40 bits)
  localparam int MUL_A_W   = DIV_N_W;
  localparam int MUL_B_W   = DIAM_W + 20;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic             operation;
    logic [CAP_W-1:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] rpm_q16;
    logic [OUT_W-1:0] speed_kph_q16;
    logic [WIN_W-1:0] next_window_ms;
    logic             pulse_seen;
  } out_item_t;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } serial_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAP_DIV,
    ST_RPS_DIV,
    ST_SPD_MUL,
    ST_WIN_DIV,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ sv/wtag_serial_div.sv @@
// ----------------------------------------------------------------------------
// wtag_serial_div: restoring divider, one quotient bit per cycle
// done pulses for one cycle once every quotient bit is shifted in; quotient holds.
// ----------------------------------------------------------------------------
`default_nettype none

module wtag_serial_div import wtag_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output serial_stat_t       stat,
  output logic [DIV_N_W-1:0] quotient
);

  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;
  logic                 done;

  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W:0]     diff;
  logic                 take;

  always_comb begin
    shifted = {rem, quo[DIV_N_W-1]};
    diff    = shifted - {1'b0, dsr};
    take    = ~diff[DIV_D_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_N_W - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_N_W-2:0], take};
      rem <= take ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

`default_nettype wire

@@ sv/wtag_serial_mul.sv @@
// ----------------------------------------------------------------------------
// wtag_serial_mul: shift-add multiplier, one multiplier bit per cycle
// done pulses for one cycle once every multiplier bit is used; product holds.
// ----------------------------------------------------------------------------
`default_nettype none

module wtag_serial_mul import wtag_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] mcand,
  input  logic [MUL_B_W-1:0] mplier,
  output serial_stat_t       stat,
  output logic [PROD_W-1:0]  product
);

  logic [MUL_A_W-1:0]   acand;
  logic [MUL_A_W-1:0]   hi;
  logic [MUL_B_W-1:0]   lo;
  logic [MUL_CNT_W-1:0] count;
  logic                 busy;
  logic                 done;
  logic [MUL_A_W:0]     sum;

  // upper half accumulates, low bits drop into the multiplier register
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, acand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= MUL_CNT_W'(MUL_B_W - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acand <= mcand;
      hi    <= '0;
      lo    <= mplier;
    end else if (busy) begin
      hi <= sum[MUL_A_W:1];
      lo <= {sum[0], lo[MUL_B_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = {hi, lo};

endmodule

`default_nettype wire

@@ sv/wheel_tachometer_adaptive_gate.sv @@
// Tick that does not end a window: handled in its accept cycle, one per cycle while the block is idle.
// Nonzero capture: serial divide of the timer clock; the next request is taken once it is done.
// Window end: rps divide (diameter*K multiply alongside), then speed multiply, then
//   1000/rps when needed; the next request is taken once the result enters the output register.
// Output register decouples the result; a finished window waits only if it is full.
// Synchronous reset: registers 45 / 10486, window 500 ms, no clearing pass.
// ----------------------------------------------------------------------------
// wheel_tachometer_adaptive_gate: period tachometer with adaptive window
// Capture periods give frequency; each window end reports rpm, speed, next window.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_tachometer_adaptive_gate import wtag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  state_t state, state_next;

  logic [COG_W-1:0]  teeth;
  logic [DIAM_W-1:0] diameter;
  logic              pulse_flag;
  logic [FREQ_W-1:0] held_freq;
  logic [LEN_W-1:0]  window_length;
  logic [LEN_W-1:0]  elapsed;
  logic [DIV_N_W-1:0] rps;
  logic [OUT_W-1:0]  rpm;
  logic [OUT_W-1:0]  speed;
  logic [WIN_W-1:0]  nxt;

  logic               div_start;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  serial_stat_t       div_stat;
  logic [DIV_N_W-1:0] div_q;

  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  serial_stat_t       mul_stat;
  logic [PROD_W-1:0]  mul_p;

  logic              in_accept;
  logic [LEN_W-1:0]  elapsed_inc;
  logic              window_end;
  logic              cap_start;
  logic [COG_W-1:0]  cogs;
  logic [FREQ_W-1:0] freq_sel;
  logic [FREQ_W-1:0] irps;
  logic              irps_mid;
  logic              out_load;
  logic [OUT_W-1:0]  speed_sat;

  wtag_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .stat     (div_stat),
    .quotient (div_q)
  );

  wtag_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .stat    (mul_stat),
    .product (mul_p)
  );

  assign in_stall    = (state != ST_IDLE);
  assign in_accept   = in_valid & ~in_stall;
  assign elapsed_inc = elapsed + 1'b1;
  assign window_end  = in_accept && (in_data.operation == OP_TICK) &&
                       (elapsed_inc >= window_length);
  assign cap_start   = in_accept && (in_data.operation == OP_CAPTURE) &&
                       (in_data.capture_value != '0);
  assign cogs        = (teeth == '0) ? COG_W'(1) : teeth;
  assign freq_sel    = pulse_flag ? held_freq : '0;
  assign irps        = rps[DIV_N_W-1:Q_FRAC];
  assign irps_mid    = (irps > IRPS_SLOW_MAX) && (irps <= IRPS_FAST_MAX);
  // product carries 32 fraction bits too many; anything above 49 bits saturates
  assign speed_sat   = (|mul_p[PROD_W-1:SPEED_SHIFT+OUT_W]) ? '1 :
                       mul_p[SPEED_SHIFT+OUT_W-1:SPEED_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_n      = '0;
    div_d      = '0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cap_start) begin
          div_start  = 1'b1;
          div_n      = DIV_N_W'(TIMER_CLOCK_HZ);
          div_d      = in_data.capture_value;
          state_next = ST_CAP_DIV;
        end else if (window_end) begin
          // rps divide and diameter * K run side by side
          div_start  = 1'b1;
          div_n      = {freq_sel, Q_FRAC'(0)};
          div_d      = DIV_D_W'(cogs);
          mul_start  = 1'b1;
          mul_a      = MUL_A_W'(SPEED_K_Q16);
          mul_b      = MUL_B_W'(diameter);
          state_next = ST_RPS_DIV;
        end
      end
      ST_CAP_DIV: begin
        if (div_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_RPS_DIV: begin
        if (div_stat.done) begin
          mul_start  = 1'b1;
          mul_a      = div_q;
          mul_b      = mul_p[MUL_B_W-1:0];
          state_next = ST_SPD_MUL;
        end
      end
      ST_SPD_MUL: begin
        if (mul_stat.done) begin
          if (irps_mid) begin
            div_start  = 1'b1;
            div_n      = DIV_N_W'(WINDOW_SCALE);
            div_d      = DIV_D_W'(irps);
            state_next = ST_WIN_DIV;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_WIN_DIV: begin
        if (div_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      teeth    <= TEETH_RESET;
      diameter <= DIAMETER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEETH:    teeth    <= cfg_data[COG_W-1:0];
        REG_DIAMETER: diameter <= cfg_data[DIAM_W-1:0];
      endcase
    end
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_flag    <= 1'b0;
      held_freq     <= '0;
      window_length <= INITIAL_WINDOW;
      elapsed       <= '0;
    end else begin
      if (in_accept && in_data.operation == OP_CAPTURE) begin
        pulse_flag <= 1'b1;
      end
      if (in_accept && in_data.operation == OP_TICK) begin
        elapsed <= window_end ? '0 : elapsed_inc;
      end
      if (state == ST_CAP_DIV && div_stat.done) begin
        held_freq <= div_q[FREQ_W-1:0];
      end
      if (out_load) begin
        pulse_flag    <= 1'b0;
        window_length <= LEN_W'(nxt);
      end
    end
  end

  // window-end datapath
  always_ff @(posedge clk) begin
    if (state == ST_RPS_DIV && div_stat.done) begin
      rps <= div_q;
      rpm <= {div_q, 6'd0} - {4'd0, div_q, 2'd0};
    end
    if (state == ST_SPD_MUL && mul_stat.done) begin
      speed <= speed_sat;
      if (irps <= IRPS_SLOW_MAX) begin
        nxt <= MAX_WINDOW_MS;
      end else if (irps > IRPS_FAST_MAX) begin
        nxt <= MIN_WINDOW_MS;
      end
    end
    if (state == ST_WIN_DIV && div_stat.done) begin
      nxt <= div_q[WIN_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid & out_stall) | out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.rpm_q16        <= rpm;
      out_data.speed_kph_q16  <= speed;
      out_data.next_window_ms <= nxt;
      out_data.pulse_seen     <= pulse_flag;
    end
  end

  // diameter * K must be ready by the time the rps divide finishes
  a_dk_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RPS_DIV && div_stat.done) |-> !mul_stat.busy)
    else $error("diameter product not ready at rps divide end");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_CAP_DIV || state == ST_RPS_DIV ||
                       state == ST_WIN_DIV))
    else $error("divider busy outside a divide state");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (window_length >= LEN_W'(MIN_WINDOW) &&
                  window_length <= LEN_W'(MAX_WINDOW)))
    else $error("next window out of range");

  a_flag_cleared: assert property (@(posedge clk) disable iff (rst)
    out_load |=> !pulse_flag)
    else $error("pulse flag kept past window end");

endmodule

`default_nettype wire

@@ sim/wtag_monitor.sv @@
// ----------------------------------------------------------------------------
// wtag_monitor: prediction and comparison for the wheel tachometer
// Watches the config port and both request channels, tracks the tachometer
// state, queues the reading each window end should produce and compares
// every accepted reading against it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtag_monitor import wtag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  output int                    fail_count,
  output int                    pending,
  output int                    windows_ended
);

  localparam logic [63:0] OUT_SAT = (64'd1 << OUT_W) - 64'd1;

  logic [COG_W-1:0]  cog_reg;
  logic [DIAM_W-1:0] diam_reg;
  logic              pulse_flag;
  logic [FREQ_W-1:0] held_freq;
  logic [LEN_W-1:0]  win_len;
  logic [LEN_W-1:0]  elapsed;
  out_item_t         expected_readings[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    windows_ended = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    out_item_t    want;
    logic [63:0]  cogs;
    logic [63:0]  freq;
    logic [63:0]  rps;
    logic [63:0]  rpm;
    logic [63:0]  irps;
    logic [63:0]  nxt;
    logic [127:0] spd;
    if (rst) begin
      cog_reg    = TEETH_RESET;
      diam_reg   = DIAMETER_RESET;
      pulse_flag = 1'b0;
      held_freq  = '0;
      win_len    = INITIAL_WINDOW;
      elapsed    = '0;
      expected_readings.delete();
      windows_ended = 0;
    end else begin
      // the reading leaving now cannot come from the request entering now
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("reading with none pending", out_data.rpm_q16, 0);
        end else begin
          want = expected_readings.pop_front();
          if (out_data.rpm_q16 !== want.rpm_q16)
            report_mismatch("rpm_q16", out_data.rpm_q16, want.rpm_q16);
          if (out_data.speed_kph_q16 !== want.speed_kph_q16)
            report_mismatch("speed_kph_q16", out_data.speed_kph_q16, want.speed_kph_q16);
          if (out_data.next_window_ms !== want.next_window_ms)
            report_mismatch("next_window_ms", out_data.next_window_ms, want.next_window_ms);
          if (out_data.pulse_seen !== want.pulse_seen)
            report_mismatch("pulse_seen", out_data.pulse_seen, want.pulse_seen);
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_TEETH:    cog_reg  = cfg_data[COG_W-1:0];
          REG_DIAMETER: diam_reg = cfg_data[DIAM_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_CAPTURE) begin
          // zero capture keeps the frequency but still counts as a pulse
          if (in_data.capture_value != '0)
            held_freq = FREQ_W'(64'(TIMER_CLOCK_HZ) / 64'(in_data.capture_value));
          pulse_flag = 1'b1;
        end else begin
          elapsed = elapsed + 1'b1;
          if (elapsed >= win_len) begin
            cogs = (cog_reg == '0) ? 64'd1 : 64'(cog_reg);
            freq = pulse_flag ? 64'(held_freq) : 64'd0;
            rps  = (freq << Q_FRAC) / cogs;
            irps = freq / cogs;
            rpm  = rps * 64'd60;
            if (rpm > OUT_SAT)
              rpm = OUT_SAT;
            spd = (128'(rps) * 128'(diam_reg) * 128'(SPEED_K_Q16)) >> SPEED_SHIFT;
            if (spd > 128'(OUT_SAT))
              spd = 128'(OUT_SAT);
            if (irps == 0) begin
              nxt = MAX_WINDOW;
            end else begin
              nxt = WINDOW_SCALE / irps;
              if (nxt < MIN_WINDOW)
                nxt = MIN_WINDOW;
              if (nxt > MAX_WINDOW)
                nxt = MAX_WINDOW;
            end
            want.rpm_q16        = OUT_W'(rpm);
            want.speed_kph_q16  = OUT_W'(spd);
            want.next_window_ms = WIN_W'(nxt);
            want.pulse_seen     = pulse_flag;
            expected_readings.push_back(want);
            windows_ended++;
            win_len    = LEN_W'(nxt);
            elapsed    = '0;
            pulse_flag = 1'b0;
          end
        end
      end
    end
    pending = expected_readings.size();
  end

endmodule

@@ sim/tb_wheel_tachometer_adaptive_gate.sv @@
// ----------------------------------------------------------------------------
// tb_wheel_tachometer_adaptive_gate: stimulus for the wheel tachometer
// Directed windows cover the zero, slow, fast and saturating cases and a long
// output hold-off, then random capture/tick windows run under several register
// settings with random idling on both channels and full drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wheel_tachometer_adaptive_gate;
  import wtag_pkg::*;

  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 800;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TOTAL_ITEMS    = 2000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  int fail_count;
  int pending;
  int windows_ended;

  logic             hold_req  = 1'b0;
  logic             hold_done = 1'b0;
  int               hold_left = 0;
  logic             calm      = 1'b0;
  int               idle_cycles = 0;
  int               items_sent  = 0;
  logic [COG_W-1:0] cur_cogs    = TEETH_RESET;

  wheel_tachometer_adaptive_gate DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  wtag_monitor u_monitor (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .windows_ended (windows_ended)
  );

  always #1 clk = ~clk;

  // receiver: random stalls, one long hold-off on request, none while calm
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 36);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // capture count that gives roughly the wanted integer rps at the current cogs
  function automatic logic [CAP_W-1:0] capture_for_rate(input int unsigned rate);
    logic [63:0] cogs;
    logic [63:0] cap;
    cogs = (cur_cogs == '0) ? 64'd1 : 64'(cur_cogs);
    cap  = 64'(TIMER_CLOCK_HZ) / (64'(rate) * cogs);
    return (cap == 0) ? CAP_W'(1) : CAP_W'(cap);
  endfunction

  function automatic logic [CAP_W-1:0] pick_capture();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      2:       return CAP_W'($urandom_range(1, 200));
      default: return capture_for_rate($urandom_range(1, 150));
    endcase
  endfunction

  // one request per call; valid stays up across back-to-back requests
  task automatic send_item(input logic op, input logic [CAP_W-1:0] cap);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {op, cap};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // ticks, with optional stray captures, until the window closes
  task automatic finish_window(input int noise_pct);
    int seen;
    seen = windows_ended;
    while (windows_ended == seen) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(OP_CAPTURE, pick_capture());
      else
        send_item(OP_TICK, $urandom);
    end
  endtask

  // drain fully, let any capture divide finish, then write both registers
  task automatic configure(input logic [COG_W-1:0] cogs, input logic [DIAM_W-1:0] diam);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TEETH;
    cfg_data  <= CFG_DATA_W'({$urandom, cogs});
    @(negedge clk);
    cfg_index <= REG_DIAMETER;
    cfg_data  <= diam;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_cogs = cogs;
  endtask

  task automatic random_phase(input logic [COG_W-1:0] cogs, input logic [DIAM_W-1:0] diam,
                              input int n);
    int start;
    configure(cogs, diam);
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(0, 9) < 8)
        send_item(OP_CAPTURE, pick_capture());
      finish_window(5);
    end
  endtask

  initial begin
    int rates[5];
    rates = '{1, 5, 6, 100, 101};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first 500 ms window at reset settings: pulses seen but no frequency
    send_item(OP_CAPTURE, '1);
    send_item(OP_CAPTURE, '0);
    finish_window(0);
    finish_window(0);

    // zero cog count acts as one; full diameter saturates the speed
    configure('0, '1);
    send_item(OP_CAPTURE, CAP_W'(1));
    finish_window(0);
    foreach (rates[i]) begin
      send_item(OP_CAPTURE, capture_for_rate(rates[i]));
      finish_window(0);
    end
    send_item(OP_CAPTURE, CAP_W'(64'(TIMER_CLOCK_HZ) + 64'd1));
    finish_window(0);
    send_item(OP_CAPTURE, CAP_W'(1000));
    send_item(OP_CAPTURE, '0);
    finish_window(0);

    // fast windows while the receiver holds off: the block backs up
    configure(COG_W'(1), '0);
    hold_req <= 1'b1;
    repeat (10) begin
      send_item(OP_CAPTURE, capture_for_rate($urandom_range(100, 150)));
      finish_window(0);
    end

    random_phase('1, DIAM_W'(655360), 50);
    calm <= 1'b1;
    random_phase(TEETH_RESET, DIAMETER_RESET, 120);
    calm <= 1'b0;
    random_phase(COG_W'(1), DIAM_W'(1), 50);
    do
      random_phase(COG_W'($urandom_range(0, 65535)), DIAM_W'($urandom), 50);
    while (items_sent < TOTAL_ITEMS);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
